// ===== hw/rtl/htba_pkg.sv =====
// Shared types and constants for the hit time bin accumulator.
`timescale 1ns / 1ps
package htba_pkg;

   localparam int PIXEL_COUNT = 1024;
   localparam int BIN_SLOTS   = 64;

   localparam int PIX_W      = $clog2(PIXEL_COUNT);
   localparam int SLOT_W     = $clog2(BIN_SLOTS);
   localparam int COUNT_W    = $clog2(BIN_SLOTS + 1);
   localparam int CELL_W     = PIX_W + SLOT_W;
   localparam int CELL_COUNT = PIXEL_COUNT * BIN_SLOTS;
   localparam int DIV_STEPS  = 32;

   localparam logic [11:0]        PIXEL_LIMIT   = 12'(PIXEL_COUNT);
   localparam logic [15:0]        WIDTH_RESET   = 16'd1000;
   localparam logic signed [31:0] TIME_MIN_INIT = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] TIME_MAX_INIT = 32'sh8000_0000;

   typedef struct packed {
      logic              req_type;
      logic [10:0]       pixel_index;
      logic signed [31:0] arrival_time_ps;
      logic [15:0]       hit_weight;
   } htba_req_type;

   typedef struct packed {
      logic               hit_accepted;
      logic [5:0]         slot_index;
      logic               slot_valid;
      logic               slot_new;
      logic               overflow_seen;
      logic [6:0]         bins_used;
      logic [31:0]        pixel_total;
      logic [47:0]        pixel_square_total;
      logic [31:0]        slot_total;
      logic signed [31:0] earliest_time_ps;
      logic signed [31:0] latest_time_ps;
   } htba_rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIV,
      ST_SEARCH,
      ST_SLOTRD,
      ST_FINISH
   } htba_state_type;

   // Controller to datapath
   typedef struct packed {
      logic              capture;
      logic              clear_state;
      logic              sweep_en;
      logic [CELL_W-1:0] sweep_addr;
      logic              div_step;
      logic              srch_rd;
      logic [SLOT_W-1:0] srch_addr;
      logic              alloc;
      logic              finish;
   } htba_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic req_clear;
      logic req_in_range;
      logic req_timed;
      logic srch_done;
      logic rsp_free;
   } htba_status_type;

endpackage

// ===== hw/rtl/htba_ctrl.sv =====
// Sequencer for the hit time bin accumulator: sweep, divide, search, update.
`timescale 1ns / 1ps
module htba_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  htba_pkg::htba_status_type status,
   output htba_pkg::htba_cmd_type    cmd
);
   import htba_pkg::*;

   htba_state_type    state_ff, state_in;
   logic [CELL_W-1:0] cnt_ff, cnt_in;
   logic              pending_ff, pending_in;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         pending_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         pending_ff <= pending_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      cnt_in         = '0;
      pending_in     = pending_ff;
      req_stall      = 1'b1;
      cmd            = '0;
      cmd.sweep_addr = cnt_ff;
      cmd.srch_addr  = cnt_ff[SLOT_W-1:0];
      case (state_ff)
         ST_CLEAR: begin
            cmd.sweep_en = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CELL_W'(CELL_COUNT - 1)) begin
               cnt_in     = '0;
               pending_in = 1'b0;
               state_in   = pending_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.req_clear) begin
                  cmd.clear_state = 1'b1;
                  pending_in      = 1'b1;
                  state_in        = ST_CLEAR;
               end else if (!status.req_in_range || !status.req_timed) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 1'b1;
            if (cnt_ff == CELL_W'(DIV_STEPS - 1)) begin
               cnt_in   = '0;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            cmd.srch_rd = 1'b1;
            cnt_in      = cnt_ff + 1'b1;
            if (status.srch_done) begin
               state_in = ST_SLOTRD;
            end
         end
         ST_SLOTRD: begin
            cmd.alloc = 1'b1;
            state_in  = ST_FINISH;
         end
         ST_FINISH: begin
            if (status.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== hw/rtl/htba_datapath.sv =====
// Datapath: sum memories, bin divider, bin table, time range and result register.
`timescale 1ns / 1ps
module htba_datapath (
   input  logic                      clock,
   input  logic                      reset,
   input  htba_pkg::htba_req_type    req_data,
   output htba_pkg::htba_rsp_type    rsp_data,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   input  logic                      csr_wr_en,
   input  logic [15:0]               csr_wr_data,
   input  htba_pkg::htba_cmd_type    cmd,
   output htba_pkg::htba_status_type status
);
   import htba_pkg::*;

   // memories
   logic [31:0] psum_mem [PIXEL_COUNT];
   logic [47:0] psq_mem  [PIXEL_COUNT];
   logic [31:0] ssum_mem [CELL_COUNT];
   logic [47:0] ssq_mem  [CELL_COUNT];
   logic [31:0] tbl_mem  [BIN_SLOTS];

   htba_req_type       item_ff;
   logic               in_range_ff;
   logic [31:0]        wsq_ff;
   logic [15:0]        width_ff;
   logic [31:0]        psum_rd_ff, ssum_rd_ff, tbl_rd_ff;
   logic [47:0]        psq_rd_ff, ssq_rd_ff;
   logic [31:0]        dvd_ff;
   logic [16:0]        rem_ff;
   logic [15:0]        dsor_ff;
   logic               neg_ff;
   logic               rd_valid_ff;
   logic [SLOT_W-1:0]  rd_idx_ff;
   logic               hit_ff, svalid_ff, snew_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               ovf_ff;
   logic signed [31:0] tmin_ff, tmax_ff;
   htba_rsp_type       rsp_ff;
   logic               rsp_valid_ff;

   logic [PIX_W-1:0]   pix;
   logic               in_range;
   logic [31:0]        mag;
   logic [16:0]        rem_sh;
   logic               ge;
   logic [31:0]        bin;
   logic               match, exhausted, room;
   logic [SLOT_W-1:0]  slot_sel;
   logic [32:0]        psum_add, ssum_add;
   logic [48:0]        psq_add, ssq_add;
   logic [31:0]        psum_new, ssum_new;
   logic [47:0]        psq_new, ssq_new;
   logic               accepted, timed_hit, slot_wr;
   logic signed [31:0] tmin_new, tmax_new;
   htba_rsp_type       rsp_in;

   assign pix      = item_ff.pixel_index[PIX_W-1:0];
   assign in_range = {1'b0, req_data.pixel_index} < PIXEL_LIMIT;
   assign mag      = req_data.arrival_time_ps[31] ? (32'd0 - req_data.arrival_time_ps)
                                                  : req_data.arrival_time_ps;

   assign status.req_clear    = req_data.req_type;
   assign status.req_in_range = in_range;
   assign status.req_timed    = req_data.arrival_time_ps != 32'sd0;
   assign status.srch_done    = match || exhausted;
   assign status.rsp_free     = !rsp_valid_ff || !rsp_stall;

   // item capture, squared weight
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff     <= req_data;
         in_range_ff <= in_range;
         wsq_ff      <= 32'(req_data.hit_weight) * 32'(req_data.hit_weight);
      end
   end

   // pixel sum memories: read at capture, write on finish or sweep
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         psum_rd_ff <= psum_mem[req_data.pixel_index[PIX_W-1:0]];
         psq_rd_ff  <= psq_mem[req_data.pixel_index[PIX_W-1:0]];
      end
      if (cmd.sweep_en) begin
         psum_mem[cmd.sweep_addr[PIX_W-1:0]] <= '0;
         psq_mem[cmd.sweep_addr[PIX_W-1:0]]  <= '0;
      end else if (cmd.finish && accepted) begin
         psum_mem[pix] <= psum_new;
         psq_mem[pix]  <= psq_new;
      end
   end

   // slot sum memories: read in slot read step, write on finish or sweep
   always_ff @(posedge clock) begin
      if (cmd.alloc) begin
         ssum_rd_ff <= ssum_mem[{pix, slot_sel}];
         ssq_rd_ff  <= ssq_mem[{pix, slot_sel}];
      end
      if (cmd.sweep_en) begin
         ssum_mem[cmd.sweep_addr] <= '0;
         ssq_mem[cmd.sweep_addr]  <= '0;
      end else if (cmd.finish && slot_wr) begin
         ssum_mem[{pix, slot_ff}] <= ssum_new;
         ssq_mem[{pix, slot_ff}]  <= ssq_new;
      end
   end

   // restoring divider, one quotient bit per step
   assign rem_sh = {rem_ff[15:0], dvd_ff[31]};
   assign ge     = rem_sh >= {1'b0, dsor_ff};

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         dvd_ff  <= mag;
         rem_ff  <= '0;
         dsor_ff <= (width_ff == 16'd0) ? 16'd1 : width_ff;
         neg_ff  <= req_data.arrival_time_ps[31];
      end else if (cmd.div_step) begin
         dvd_ff <= {dvd_ff[30:0], ge};
         rem_ff <= ge ? (rem_sh - {1'b0, dsor_ff}) : rem_sh;
      end
   end

   // floor-style bin: negative times give -q-1, saturating at the low end
   assign bin = !neg_ff ? dvd_ff : (dvd_ff[31] ? 32'h8000_0000 : ~dvd_ff);

   // bin table search, one slot per cycle
   assign match     = rd_valid_ff && (tbl_rd_ff == bin) && ({1'b0, rd_idx_ff} < count_ff);
   assign exhausted = (count_ff == '0) ||
                      (rd_valid_ff && ((COUNT_W'(rd_idx_ff) + 1'b1) >= count_ff));
   assign room      = count_ff < COUNT_W'(BIN_SLOTS);
   assign slot_sel  = hit_ff ? slot_ff : count_ff[SLOT_W-1:0];

   always_ff @(posedge clock) begin
      if (cmd.srch_rd) begin
         tbl_rd_ff <= tbl_mem[cmd.srch_addr];
      end
      if (cmd.alloc && !hit_ff && room) begin
         tbl_mem[count_ff[SLOT_W-1:0]] <= bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= cmd.srch_rd;
      end
      rd_idx_ff <= cmd.srch_addr;
   end

   // search outcome and slot allocation
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         hit_ff    <= 1'b0;
         svalid_ff <= 1'b0;
         snew_ff   <= 1'b0;
      end else if (cmd.srch_rd && match && !hit_ff) begin
         hit_ff  <= 1'b1;
         slot_ff <= rd_idx_ff;
      end else if (cmd.alloc) begin
         svalid_ff <= hit_ff || room;
         snew_ff   <= !hit_ff && room;
         slot_ff   <= slot_sel;
      end
   end

   // scalar state: bin width, slot count, overflow, time range
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff <= WIDTH_RESET;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         tmin_ff  <= TIME_MIN_INIT;
         tmax_ff  <= TIME_MAX_INIT;
      end else begin
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
         if (cmd.clear_state) begin
            count_ff <= '0;
            ovf_ff   <= 1'b0;
            tmin_ff  <= TIME_MIN_INIT;
            tmax_ff  <= TIME_MAX_INIT;
         end else begin
            if (cmd.alloc && !hit_ff) begin
               if (room) begin
                  count_ff <= count_ff + 1'b1;
               end else begin
                  ovf_ff <= 1'b1;
               end
            end
            if (cmd.finish && timed_hit) begin
               tmin_ff <= tmin_new;
               tmax_ff <= tmax_new;
            end
         end
      end
   end

   // saturating sums
   assign psum_add = {1'b0, psum_rd_ff} + {17'd0, item_ff.hit_weight};
   assign psq_add  = {1'b0, psq_rd_ff} + {17'd0, wsq_ff};
   assign ssum_add = {1'b0, ssum_rd_ff} + {17'd0, item_ff.hit_weight};
   assign ssq_add  = {1'b0, ssq_rd_ff} + {17'd0, wsq_ff};
   assign psum_new = psum_add[32] ? '1 : psum_add[31:0];
   assign psq_new  = psq_add[48] ? '1 : psq_add[47:0];
   assign ssum_new = ssum_add[32] ? '1 : ssum_add[31:0];
   assign ssq_new  = ssq_add[48] ? '1 : ssq_add[47:0];

   assign accepted  = !item_ff.req_type && in_range_ff;
   assign timed_hit = accepted && (item_ff.arrival_time_ps != 32'sd0);
   assign slot_wr   = timed_hit && svalid_ff;
   assign tmin_new  = (item_ff.arrival_time_ps < tmin_ff) ? item_ff.arrival_time_ps : tmin_ff;
   assign tmax_new  = (item_ff.arrival_time_ps > tmax_ff) ? item_ff.arrival_time_ps : tmax_ff;

   // result beat
   always_comb begin
      rsp_in                    = '0;
      rsp_in.hit_accepted       = accepted;
      rsp_in.overflow_seen      = ovf_ff;
      rsp_in.bins_used          = 7'(count_ff);
      rsp_in.earliest_time_ps   = timed_hit ? tmin_new : tmin_ff;
      rsp_in.latest_time_ps     = timed_hit ? tmax_new : tmax_ff;
      if (accepted) begin
         rsp_in.pixel_total        = psum_new;
         rsp_in.pixel_square_total = psq_new;
      end
      if (slot_wr) begin
         rsp_in.slot_index = 6'(slot_ff);
         rsp_in.slot_valid = 1'b1;
         rsp_in.slot_new   = snew_ff;
         rsp_in.slot_total = ssum_new;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/hit_time_bin_accumulator.sv =====
// Top level of the hit time bin accumulator: controller plus datapath.
`timescale 1ns / 1ps
// Usage:
//  req_* carries one beat per hit or clear request (valid/stall handshake);
//  rsp_* returns exactly one result beat per request, in order.
//  csr_wr_en/csr_wr_data load the bin width in ps; write only while idle.
// Sequence:
//  An out-of-range or untimed hit goes from capture straight to the final
//  update. A timed hit passes through capture, the divider (one quotient
//  bit per cycle), the bin table search (one slot per cycle on the table's
//  single read port), a slot read step and a final update step. One item
//  is in flight at a time.
// Reset and clear:
//  After reset, and for each clear request, the per-cell sum memories are
//  swept one cell per cycle, PIXEL_COUNT * BIN_SLOTS = 65536 cells in all;
//  req_stall stays high throughout. A clear request's result follows the sweep.
// Stall:
//  The result sits in an output register; a new item is taken while it
//  waits, and the next result holds until rsp_stall drops.
module hit_time_bin_accumulator (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  htba_pkg::htba_req_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output htba_pkg::htba_rsp_type rsp_data,
   input  logic                   csr_wr_en,
   input  logic [15:0]            csr_wr_data
);
   import htba_pkg::*;

   htba_cmd_type    cmd;
   htba_status_type status;

   htba_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   htba_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_data    (rsp_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the hit time bin accumulator.
`timescale 1ns / 1ps
module testbench;
   import htba_pkg::*;

   localparam longint CYCLE_LIMIT = 10000000;
   localparam int     SETTLE      = 60;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   htba_req_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   htba_rsp_type rsp_data;
   logic         csr_wr_en = 1'b0;
   logic [15:0]  csr_wr_data = '0;

   // Mirror of the accumulator state
   logic [15:0]  width_reg;
   logic [31:0]  pix_sum_m [PIXEL_COUNT];
   logic [47:0]  pix_sq_m [PIXEL_COUNT];
   logic [31:0]  cell_sum_m [CELL_COUNT];
   longint       bin_tab_m [BIN_SLOTS];
   int           bins_m;
   longint       tmin_m;
   longint       tmax_m;
   bit           ovf_m;

   htba_rsp_type pending_rsp [$];
   int           error_count = 0;
   longint       cycles = 0;
   bit           calm = 1'b0;

   hit_time_bin_accumulator DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("testbench: done, errors");
         $finish;
      end
   end

   function automatic bit idle_roll();
      return !calm && ($urandom_range(0, 99) < 6);
   endfunction

   // Receiver back-pressure
   always @(negedge clock) begin
      rsp_stall <= idle_roll();
   end

   function automatic void wipe_state();
      foreach (pix_sum_m[i]) begin
         pix_sum_m[i] = '0;
         pix_sq_m[i] = '0;
      end
      foreach (cell_sum_m[i]) cell_sum_m[i] = '0;
      foreach (bin_tab_m[i]) bin_tab_m[i] = 0;
      bins_m = 0;
      tmin_m = 64'sd2147483647;
      tmax_m = -64'sd2147483648;
      ovf_m = 1'b0;
   endfunction

   // Expected result of one beat; updates the mirrored state
   function automatic htba_rsp_type accumulate_hit(htba_req_type r);
      htba_rsp_type o;
      longint t, wdt, q;
      longint unsigned s, wsq;
      int k, cell_idx;
      bit found;
      o = '0;
      t = longint'(r.arrival_time_ps);
      wsq = longint'(r.hit_weight) * longint'(r.hit_weight);
      if (r.req_type) begin
         wipe_state();
      end else if (r.pixel_index < PIXEL_COUNT) begin
         o.hit_accepted = 1'b1;
         s = longint'(pix_sum_m[r.pixel_index]) + r.hit_weight;
         pix_sum_m[r.pixel_index] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
         s = longint'(pix_sq_m[r.pixel_index]) + wsq;
         pix_sq_m[r.pixel_index] = (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
         o.pixel_total = pix_sum_m[r.pixel_index];
         o.pixel_square_total = pix_sq_m[r.pixel_index];
         if (t != 0) begin
            if (t < tmin_m) tmin_m = t;
            if (t > tmax_m) tmax_m = t;
            wdt = (width_reg == 0) ? 1 : longint'(width_reg);
            q = t / wdt;
            if (t < 0) q = q - 1;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            found = 1'b0;
            k = 0;
            while (k < bins_m && !found) begin
               if (bin_tab_m[k] == q) found = 1'b1;
               else k++;
            end
            if (!found && bins_m < BIN_SLOTS) begin
               k = bins_m;
               bin_tab_m[k] = q;
               bins_m++;
               found = 1'b1;
               o.slot_new = 1'b1;
            end
            if (found) begin
               cell_idx = r.pixel_index * BIN_SLOTS + k;
               s = longint'(cell_sum_m[cell_idx]) + r.hit_weight;
               cell_sum_m[cell_idx] = (s > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
               o.slot_valid = 1'b1;
               o.slot_index = k[5:0];
               o.slot_total = cell_sum_m[cell_idx];
            end else begin
               ovf_m = 1'b1;
            end
         end
      end
      o.overflow_seen = ovf_m;
      o.bins_used = bins_m[6:0];
      o.earliest_time_ps = tmin_m[31:0];
      o.latest_time_ps = tmax_m[31:0];
      return o;
   endfunction

   // Send one beat; valid stays high until the next idle gap or beat
   task automatic send_beat(htba_req_type r);
      while (idle_roll()) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data = r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rsp.insert(pending_rsp.size(), accumulate_hit(r));
      @(negedge clock);
   endtask

   task automatic send_hit(int pix, longint t, int w);
      htba_req_type r;
      r.req_type = 1'b0;
      r.pixel_index = pix[10:0];
      r.arrival_time_ps = t[31:0];
      r.hit_weight = w[15:0];
      send_beat(r);
   endtask

   task automatic send_clear();
      htba_req_type r;
      r = '0;
      r.req_type = 1'b1;
      r.pixel_index = 11'($urandom);
      r.arrival_time_ps = $urandom;
      r.hit_weight = 16'($urandom);
      send_beat(r);
   endtask

   task automatic drain();
      req_valid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task automatic write_width(logic [15:0] value);
      drain();
      csr_wr_en = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      width_reg = value;
   endtask

   // Result checker
   task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      htba_rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result beat with nothing expected");
            error_count++;
         end else begin
            e = pending_rsp.pop_front();
            check_field("hit_accepted", e.hit_accepted, rsp_data.hit_accepted);
            check_field("slot_index", e.slot_index, rsp_data.slot_index);
            check_field("slot_valid", e.slot_valid, rsp_data.slot_valid);
            check_field("slot_new", e.slot_new, rsp_data.slot_new);
            check_field("overflow_seen", e.overflow_seen, rsp_data.overflow_seen);
            check_field("bins_used", e.bins_used, rsp_data.bins_used);
            check_field("pixel_total", e.pixel_total, rsp_data.pixel_total);
            check_field("pixel_square_total", e.pixel_square_total,
                        rsp_data.pixel_square_total);
            check_field("slot_total", e.slot_total, rsp_data.slot_total);
            check_field("earliest_time_ps", e.earliest_time_ps, rsp_data.earliest_time_ps);
            check_field("latest_time_ps", e.latest_time_ps, rsp_data.latest_time_ps);
         end
      end
   end

   // Edge cases at the default width, then the narrow widths
   task automatic test_directed();
      send_hit(0, 0, 0);
      send_hit(1023, 1, 16'hFFFF);
      send_hit(1024, 5, 16'h0100);
      send_hit(2047, -5, 16'hFFFF);
      send_hit(1023, 999, 16'h8000);
      send_hit(5, -1, 16'h0001);
      send_hit(5, -1000, 16'h0200);
      send_hit(5, -1001, 16'h0300);
      send_hit(7, 64'sd2147483647, 16'h1234);
      send_hit(7, -64'sd2147483648, 16'hABCD);
      send_hit(7, 0, 16'h5555);
      send_clear();
      send_hit(1024, 10, 16'h0100);
      write_width(16'd0);
      send_hit(3, -64'sd2147483648, 16'h00FF);
      send_hit(3, -64'sd2147483647, 16'h00FF);
      write_width(16'd1);
      send_hit(3, -64'sd2147483648, 16'h0F0F);
      send_hit(3, 64'sd2147483647, 16'hF0F0);
   endtask

   // Fill every slot, then push new bins past a full table
   task automatic test_table_full();
      write_width(16'd100);
      send_clear();
      for (int b = 0; b < BIN_SLOTS + 4; b++)
         send_hit(b % 16, (b + 1) * 100 + 50, $urandom_range(0, 65535));
      send_hit(2, 150, 16'h0001);
      send_hit(2, 0, 16'h0001);
   endtask

   // Mostly clustered bins so the table fills gradually, plus noise
   task automatic random_phase(logic [15:0] w, bit do_write, int count);
      int spread, pix, wt, pick;
      longint t, wdt;
      if (do_write) write_width(w);
      drain();
      send_clear();
      wdt = (width_reg == 0) ? 1 : longint'(width_reg);
      spread = $urandom_range(40, 90);
      for (int i = 0; i < count; i++) begin
         calm = (i >= count / 3) && (i < count / 3 + 60);
         pick = $urandom_range(0, 99);
         pix = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 15);
         wt = $urandom_range(0, 65535);
         if ($urandom_range(0, 9) == 0) wt = ($urandom_range(0, 1) == 0) ? 0 : 65535;
         t = (longint'($urandom_range(0, spread)) - spread / 2) * wdt
             + longint'($urandom_range(0, 32'(wdt - 1)));
         if (pick < 8) t = 0;
         else if (pick < 14) t = longint'(int'($urandom));
         else if (pick < 19) pix = $urandom_range(1024, 2047);
         if (pick == 99) send_clear();
         else send_hit(pix, t, wt);
      end
      calm = 1'b0;
   endtask

   initial begin
      width_reg = WIDTH_RESET;
      wipe_state();
      repeat (4) @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_table_full();
      random_phase(16'd1000, 1'b0, 280);
      random_phase(16'd1, 1'b1, 280);
      random_phase(16'd65535, 1'b1, 280);
      random_phase(16'd7, 1'b1, 280);
      random_phase(16'($urandom_range(2, 65534)), 1'b1, 260);
      drain();
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end

endmodule
